[hw/rtl/lned_pkg.sv]
// lned_pkg: shared types and constants of the line editor
// character codes, result kinds, character classes, controller/datapath bundles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lned_pkg;

   localparam int LINE_DEPTH = 32;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
   localparam int CHAR_W     = 7;

   localparam logic [CHAR_W-1:0] CH_NL     = 7'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_BS     = 7'h08;
   localparam logic [CHAR_W-1:0] CH_DEL    = 7'h7F;
   localparam logic [CHAR_W-1:0] CH_HASH   = 7'h23;
   localparam logic [CHAR_W-1:0] CH_CTRL_R = 7'h12;
   localparam logic [CHAR_W-1:0] CH_AT     = 7'h40;
   localparam logic [CHAR_W-1:0] CH_CTRL_U = 7'h15;
   localparam logic [CHAR_W-1:0] CH_CTRL_W = 7'h17;
   localparam logic [CHAR_W-1:0] CH_SP     = 7'h20;
   localparam logic [CHAR_W-1:0] CH_NUL    = 7'h00;

   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_DATA = 2'd1,
      KIND_EOL  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CLS_NEWLINE,
      CLS_ERASE,
      CLS_HASH,
      CLS_REPRINT,
      CLS_KILL,
      CLS_ORD
   } cls_type;

   typedef struct packed {
      logic              load_char;
      logic              fill_dec;
      logic              fill_clr;
      logic              store_wr;
      logic              idx_clr;
      logic              idx_inc;
      logic              emit;
      logic              emit_from_ram;
      kind_type          emit_kind;
      logic [CHAR_W-1:0] emit_char;
      logic              emit_last;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    fill_zero;
      logic    fill_full;
      logic    idx_last;
      logic    slot_free;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/lned_ram.sv]
// lned_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lned_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/lned_datapath.sv]
// lned_datapath: character register, fill count, read index, line store, result register
// depends on lned_pkg and lned_ram
`timescale 1ns / 1ps
`default_nettype none

module lned_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [7:0]                    req_rx_char,
   input  wire logic                          rsp_ready,
   input  wire lned_pkg::cmd_type             cmd,
   output lned_pkg::status_type               status,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_out_kind,
   output logic [lned_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic                               rsp_last
);

   logic [lned_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [lned_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [lned_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   lned_pkg::kind_type          kind_ff, kind_in;
   logic [lned_pkg::CHAR_W-1:0] ochar_ff, ochar_in;
   logic                        last_ff, last_in;
   logic [lned_pkg::CHAR_W-1:0] ram_data;
   logic [lned_pkg::FILL_W-1:0] fill_m1;
   lned_pkg::cls_type           cls;

   lned_ram #(
      .WIDTH (lned_pkg::CHAR_W),
      .DEPTH (lned_pkg::LINE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_wr),
      .wr_addr (fill_ff[lned_pkg::ADDR_W-1:0]),
      .wr_data (char_ff),
      .rd_addr (idx_ff),
      .rd_data (ram_data)
   );

   always_comb begin
      case (char_ff) inside
         lned_pkg::CH_NL, lned_pkg::CH_CR:                     cls = lned_pkg::CLS_NEWLINE;
         lned_pkg::CH_BS, lned_pkg::CH_DEL:                    cls = lned_pkg::CLS_ERASE;
         lned_pkg::CH_HASH:                                    cls = lned_pkg::CLS_HASH;
         lned_pkg::CH_CTRL_R:                                  cls = lned_pkg::CLS_REPRINT;
         lned_pkg::CH_AT, lned_pkg::CH_CTRL_U, lned_pkg::CH_CTRL_W: cls = lned_pkg::CLS_KILL;
         default:                                              cls = lned_pkg::CLS_ORD;
      endcase
   end

   assign fill_m1 = lned_pkg::FILL_W'(fill_ff - lned_pkg::FILL_W'(1));

   always_comb begin
      status.cls       = cls;
      status.fill_zero = (fill_ff == '0);
      status.fill_full = (fill_ff == lned_pkg::FILL_W'(lned_pkg::LINE_DEPTH));
      status.idx_last  = (lned_pkg::FILL_W'(idx_ff) == fill_m1);
      status.slot_free = !valid_ff || rsp_ready;
   end

   always_comb begin
      char_in = cmd.load_char ? req_rx_char[lned_pkg::CHAR_W-1:0] : char_ff;

      fill_in = fill_ff;
      if (cmd.fill_clr) begin
         fill_in = '0;
      end else if (cmd.fill_dec) begin
         fill_in = fill_m1;
      end else if (cmd.store_wr) begin
         fill_in = lned_pkg::FILL_W'(fill_ff + lned_pkg::FILL_W'(1));
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = lned_pkg::ADDR_W'(idx_ff + lned_pkg::ADDR_W'(1));
      end

      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      ochar_in = ochar_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cmd.emit_kind;
         ochar_in = cmd.emit_from_ram ? ram_data : cmd.emit_char;
         last_in  = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
      char_ff  <= char_in;
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      ochar_ff <= ochar_in;
      last_ff  <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_char = ochar_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

[hw/rtl/lned_ctrl.sv]
// lned_ctrl: sequencer that decodes a character and steps the datapath through its beats
// depends on lned_pkg
`timescale 1ns / 1ps
`default_nettype none

module lned_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire lned_pkg::status_type status,
   output lned_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RUB_BS1,
      ST_RUB_SP,
      ST_RUB_BS2,
      ST_NL_ECHO,
      ST_RD,
      ST_DATA,
      ST_EOL
   } state_type;

   typedef enum logic [1:0] {
      MODE_DELIVER,
      MODE_REPRINT,
      MODE_KILL
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      cmd.emit_kind = lned_pkg::KIND_ECHO;
      cmd.emit_char = lned_pkg::CH_NUL;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_char = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            case (status.cls)
               lned_pkg::CLS_NEWLINE: begin
                  cmd.idx_clr = 1'b1;
                  mode_in     = MODE_DELIVER;
                  state_in    = status.fill_zero ? ST_EOL : ST_RD;
               end
               lned_pkg::CLS_ERASE: begin
                  if (!status.fill_zero) begin
                     cmd.fill_dec = 1'b1;
                     state_in     = ST_RUB_BS1;
                  end
               end
               lned_pkg::CLS_HASH: begin
                  cmd.fill_dec = !status.fill_zero;
               end
               lned_pkg::CLS_REPRINT: begin
                  cmd.idx_clr = 1'b1;
                  mode_in     = MODE_REPRINT;
                  state_in    = ST_NL_ECHO;
               end
               lned_pkg::CLS_KILL: begin
                  cmd.fill_clr = 1'b1;
                  mode_in      = MODE_KILL;
                  state_in     = ST_NL_ECHO;
               end
               default: begin
                  cmd.store_wr = !status.fill_full;
               end
            endcase
         end
         ST_RUB_BS1: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_char = lned_pkg::CH_BS;
               state_in      = ST_RUB_SP;
            end
         end
         ST_RUB_SP: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_char = lned_pkg::CH_SP;
               state_in      = ST_RUB_BS2;
            end
         end
         ST_RUB_BS2: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_char = lned_pkg::CH_BS;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_NL_ECHO: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_char = lned_pkg::CH_NL;
               cmd.emit_last = (mode_ff == MODE_KILL) || status.fill_zero;
               state_in      = cmd.emit_last ? ST_IDLE : ST_RD;
            end
         end
         ST_RD: begin
            // store read of the current index lands next cycle
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (status.slot_free) begin
               cmd.emit          = 1'b1;
               cmd.emit_from_ram = 1'b1;
               cmd.emit_kind     = (mode_ff == MODE_DELIVER) ? lned_pkg::KIND_DATA
                                                             : lned_pkg::KIND_ECHO;
               cmd.emit_last     = (mode_ff != MODE_DELIVER) && status.idx_last;
               cmd.idx_inc       = 1'b1;
               if (!status.idx_last) begin
                  state_in = ST_RD;
               end else if (mode_ff == MODE_DELIVER) begin
                  state_in = ST_EOL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EOL: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = lned_pkg::KIND_EOL;
               cmd.emit_char = lned_pkg::CH_NUL;
               cmd.emit_last = 1'b1;
               cmd.fill_clr  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_DELIVER;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/line_editor_with_erase_kill.sv]
// line_editor_with_erase_kill: top level of the terminal line editor
// depends on lned_pkg, lned_ctrl, lned_datapath (which holds lned_ram)
//
// usage
//  - req channel: one received character per beat (req_rx_char, bit 7 ignored)
//  - rsp channel: result beats of kind echo, line character or end of line;
//    rsp_last marks the final beat caused by one character
//  - a character that gives no result (stored, dropped on a full line,
//    '#' or an erase on an empty line) passes only the decode step before req_ready returns
//  - erase echo: 3 beats, one per cycle while the receiver keeps up
//  - kill: one newline echo beat
//  - reprint and line delivery walk the line store with a store read step
//    and then a result register load step per stored character, plus the
//    newline echo or end-of-line beat
//  - the store read port has registered data, which sets the separate read step
//  - a one-beat result register sits on rsp; req_ready comes back as soon as
//    the sequencer is done, even while the last beat still waits to be taken
//  - when the receiver stalls, the sequencer holds in its current step and
//    the result register keeps its beat unchanged
//  - reset clears the fill count, the sequencer and rsp_valid; store contents
//    are left as they are and are never read before being written
`timescale 1ns / 1ps
`default_nettype none

module line_editor_with_erase_kill (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_char,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_out_kind,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_last
);

   // command bundle from the sequencer, status bundle back from the datapath
   lned_pkg::cmd_type    cmd;
   lned_pkg::status_type status;

   lned_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lned_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_rx_char  (req_rx_char),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire
